### hdl/y2p_pkg.sv
// Types, codes and constants shared by the YUV 4:4:4 to planar 4:2:0 converter.
// No dependencies.
package y2p_pkg;

  localparam int unsigned MAX_PAIR_COLUMNS_DEF = 2048;
  localparam int unsigned MAX_PAIR_ROWS_DEF    = 2048;
  localparam int unsigned CFG_W                = 12;
  localparam int unsigned PADDR_W              = 3;
  localparam int unsigned CFG_IDX_W            = 1;
  localparam int unsigned QUEUE_DEPTH          = 4;
  localparam int unsigned QUEUE_PTR_W          = 2;
  localparam int unsigned LUMA_IDX_W           = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_PAIR_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAIR_ROWS    = 1'b1;

  typedef enum logic [1:0] {
    PLANE_LUMA = 2'd0,
    PLANE_CB   = 2'd1,
    PLANE_CR   = 2'd2
  } plane_e;

  typedef enum logic [1:0] {
    KIND_LEFT  = 2'd0,
    KIND_UPPER = 2'd1,
    KIND_LOWER = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_LUMA = 2'd0,
    PH_CB   = 2'd1,
    PH_CR   = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] luma_in;
    logic [7:0] cb_in;
    logic [7:0] cr_in;
  } pixel_t;

  typedef struct packed {
    plane_e                  plane;
    logic [7:0]              sample;
    logic [LUMA_IDX_W-1:0]   plane_index;
    logic                    last_of_item;
    logic                    frame_end;
  } result_t;

  typedef struct packed {
    logic [7:0]              luma;
    logic [8:0]              sum_u;
    logic [8:0]              sum_v;
    logic [LUMA_IDX_W-1:0]   luma_idx;
    logic [LUMA_IDX_W-1:0]   chroma_idx;
    kind_e                   kind;
    logic                    last_pixel;
  } item_t;

endpackage

### hdl/y2p_if.sv
// Valid/ready word channels for pixels in and plane samples out.
// Depends on y2p_pkg.
interface y2p_pix_if import y2p_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface y2p_res_if import y2p_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hdl/y2p_front.sv
// Front end: configuration registers, raster position, left chroma hold and
// classification of each pixel word. Depends on y2p_pkg and y2p_if.
module y2p_front import y2p_pkg::*; #(
  parameter int unsigned MAX_PAIR_COLUMNS = MAX_PAIR_COLUMNS_DEF,
  parameter int unsigned MAX_PAIR_ROWS    = MAX_PAIR_ROWS_DEF,
  parameter int unsigned SLOT_W           = 11
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  y2p_pix_if.sink            pix_i,
  output logic               push_o,
  output item_t              push_item_o,
  output logic [SLOT_W-1:0]  push_slot_o,
  input  logic               full_i
);

  localparam int unsigned CMP_W = 15;

  logic [CFG_W-1:0]      pc_q, pr_q;
  logic [CFG_W-1:0]      x_q, x_d, y_q, y_d;
  logic [15:0]           hold_q, hold_d;
  logic [LUMA_IDX_W-1:0] lidx_q, lidx_d, cidx_q, cidx_d;
  logic                  cfg_we;
  logic [CFG_W-1:0]      wval;
  logic [CFG_W-1:0]      clamp_c, clamp_r;
  logic [CFG_W:0]        w, h, xn, yn;
  logic [CFG_W-1:0]      xr, yr;
  logic                  oor, origin, last_pixel, accept;
  logic [LUMA_IDX_W-1:0] lidx_eff, cidx_eff;
  logic [CFG_W-2:0]      pair;
  kind_e                 kind;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  assign wval   = pwdata[CFG_W-1:0];

  always_comb begin
    if (wval == '0) begin
      clamp_c = CFG_W'(1);
    end else if (CMP_W'(wval) > CMP_W'(MAX_PAIR_COLUMNS)) begin
      clamp_c = CFG_W'(MAX_PAIR_COLUMNS);
    end else begin
      clamp_c = wval;
    end
    if (wval == '0) begin
      clamp_r = CFG_W'(1);
    end else if (CMP_W'(wval) > CMP_W'(MAX_PAIR_ROWS)) begin
      clamp_r = CFG_W'(MAX_PAIR_ROWS);
    end else begin
      clamp_r = wval;
    end
  end

  always_comb begin
    case (paddr[PADDR_W-1:2])
      CFG_PAIR_COLUMNS: prdata = 32'(pc_q);
      CFG_PAIR_ROWS:    prdata = 32'(pr_q);
      default:          prdata = '0;
    endcase
  end

  assign w      = {pc_q, 1'b0};
  assign h      = {pr_q, 1'b0};
  assign oor    = ({1'b0, x_q} >= w) || ({1'b0, y_q} >= h);
  assign xr     = oor ? '0 : x_q;
  assign yr     = oor ? '0 : y_q;
  assign origin = (xr == '0) && (yr == '0);
  assign last_pixel = ({1'b0, xr} == w - 1'b1) && ({1'b0, yr} == h - 1'b1);
  assign lidx_eff   = origin ? '0 : lidx_q;
  assign cidx_eff   = origin ? '0 : cidx_q;
  assign pair       = xr[CFG_W-1:1];

  always_comb begin
    if (!xr[0]) begin
      kind = KIND_LEFT;
    end else if (!yr[0]) begin
      kind = KIND_UPPER;
    end else begin
      kind = KIND_LOWER;
    end
  end

  assign accept      = pix_i.valid & ~full_i;
  assign pix_i.ready = ~full_i;
  assign push_o      = accept;

  always_comb begin
    push_item_o.luma       = pix_i.payload.luma_in;
    push_item_o.sum_u      = 9'(hold_q[7:0]) + 9'(pix_i.payload.cb_in);
    push_item_o.sum_v      = 9'(hold_q[15:8]) + 9'(pix_i.payload.cr_in);
    push_item_o.luma_idx   = lidx_eff;
    push_item_o.chroma_idx = cidx_eff;
    push_item_o.kind       = kind;
    push_item_o.last_pixel = last_pixel;
    if (CMP_W'(pair) >= CMP_W'(MAX_PAIR_COLUMNS)) begin
      push_slot_o = SLOT_W'(MAX_PAIR_COLUMNS - 1);
    end else begin
      push_slot_o = SLOT_W'(pair);
    end
  end

  always_comb begin
    xn     = {1'b0, xr} + 1'b1;
    yn     = {1'b0, yr};
    x_d    = x_q;
    y_d    = y_q;
    hold_d = hold_q;
    lidx_d = lidx_q;
    cidx_d = cidx_q;
    if (xn >= w) begin
      xn = '0;
      yn = yn + 1'b1;
      if (yn >= h) begin
        yn = '0;
      end
    end
    if (accept) begin
      x_d    = xn[CFG_W-1:0];
      y_d    = yn[CFG_W-1:0];
      lidx_d = lidx_eff + 1'b1;
      cidx_d = cidx_eff + LUMA_IDX_W'(kind == KIND_LOWER);
      if (kind == KIND_LEFT) begin
        hold_d = {pix_i.payload.cr_in, pix_i.payload.cb_in};
      end
    end
    if (cfg_we) begin
      x_d = '0;
      y_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= CFG_W'(1);
      pr_q   <= CFG_W'(1);
      x_q    <= '0;
      y_q    <= '0;
      hold_q <= '0;
      lidx_q <= '0;
      cidx_q <= '0;
    end else begin
      x_q    <= x_d;
      y_q    <= y_d;
      hold_q <= hold_d;
      lidx_q <= lidx_d;
      cidx_q <= cidx_d;
      if (cfg_we && paddr[PADDR_W-1:2] == CFG_PAIR_COLUMNS) begin
        pc_q <= clamp_c;
      end
      if (cfg_we && paddr[PADDR_W-1:2] == CFG_PAIR_ROWS) begin
        pr_q <= clamp_r;
      end
    end
  end

endmodule

### hdl/y2p_queue.sv
// Short queue of classified pixel words between front end and back end.
// Depends on y2p_pkg.
module y2p_queue import y2p_pkg::*; #(
  parameter int unsigned SLOT_W = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  item_t             push_item_i,
  input  logic [SLOT_W-1:0] push_slot_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output item_t             head_item_o,
  output logic [SLOT_W-1:0] head_slot_o
);

  item_t                  item_q [QUEUE_DEPTH];
  logic [SLOT_W-1:0]      slot_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_q, rd_q;
  logic [QUEUE_PTR_W:0]   cnt_q;

  assign full_o      = cnt_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
  assign empty_o     = cnt_q == '0;
  assign head_item_o = item_q[rd_q];
  assign head_slot_o = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      item_q[wr_q] <= push_item_i;
      slot_q[wr_q] <= push_slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (QUEUE_PTR_W+1)'(push_i) - (QUEUE_PTR_W+1)'(pop_i);
    end
  end

endmodule

### hdl/y2p_back.sv
// Back end: line store of upper-row chroma pair sums, block averaging and
// sequencing of the luma, U and V words into the output register.
// Depends on y2p_pkg and y2p_if.
module y2p_back import y2p_pkg::*; #(
  parameter int unsigned MAX_PAIR_COLUMNS = MAX_PAIR_COLUMNS_DEF,
  parameter int unsigned SLOT_W           = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  item_t             head_item_i,
  input  logic [SLOT_W-1:0] head_slot_i,
  output logic              pop_o,
  y2p_res_if.source         res_o
);

  logic [17:0] line_mem [MAX_PAIR_COLUMNS];
  logic [17:0] rd_q;
  item_t       cur_q;
  logic        cur_vld_q, cur_vld_d;
  phase_e      phase_q, phase_d;
  logic        res_vld_q, res_vld_d;
  result_t     res_q, res_d;
  logic        emit, last_phase;
  logic [9:0]  tot_u, tot_v;

  assign res_o.valid   = res_vld_q;
  assign res_o.payload = res_q;

  assign emit       = cur_vld_q & (~res_vld_q | res_o.ready);
  assign last_phase = (cur_q.kind == KIND_LOWER) ? (phase_q == PH_CR) : (phase_q == PH_LUMA);
  assign pop_o      = ~empty_i & (~cur_vld_q | (emit & last_phase));

  assign tot_u = 10'(cur_q.sum_u) + 10'(rd_q[8:0]);
  assign tot_v = 10'(cur_q.sum_v) + 10'(rd_q[17:9]);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      if (head_item_i.kind == KIND_UPPER) begin
        line_mem[head_slot_i] <= {head_item_i.sum_v, head_item_i.sum_u};
      end
      rd_q  <= line_mem[head_slot_i];
      cur_q <= head_item_i;
    end
    if (emit) begin
      res_q <= res_d;
    end
  end

  always_comb begin
    case (phase_q)
      PH_LUMA: begin
        res_d.plane        = PLANE_LUMA;
        res_d.sample       = cur_q.luma;
        res_d.plane_index  = cur_q.luma_idx;
        res_d.last_of_item = cur_q.kind != KIND_LOWER;
        res_d.frame_end    = (cur_q.kind != KIND_LOWER) & cur_q.last_pixel;
      end
      PH_CB: begin
        res_d.plane        = PLANE_CB;
        res_d.sample       = tot_u[9:2];
        res_d.plane_index  = cur_q.chroma_idx;
        res_d.last_of_item = 1'b0;
        res_d.frame_end    = 1'b0;
      end
      PH_CR: begin
        res_d.plane        = PLANE_CR;
        res_d.sample       = tot_v[9:2];
        res_d.plane_index  = cur_q.chroma_idx;
        res_d.last_of_item = 1'b1;
        res_d.frame_end    = cur_q.last_pixel;
      end
      default: begin
        res_d.plane        = PLANE_LUMA;
        res_d.sample       = '0;
        res_d.plane_index  = '0;
        res_d.last_of_item = 1'b0;
        res_d.frame_end    = 1'b0;
      end
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    cur_vld_d = cur_vld_q;
    res_vld_d = res_vld_q;
    if (res_o.ready) begin
      res_vld_d = 1'b0;
    end
    if (emit) begin
      res_vld_d = 1'b1;
      if (last_phase) begin
        phase_d   = PH_LUMA;
        cur_vld_d = 1'b0;
      end else if (phase_q == PH_LUMA) begin
        phase_d = PH_CB;
      end else begin
        phase_d = PH_CR;
      end
    end
    if (pop_o) begin
      cur_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LUMA;
      cur_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      cur_vld_q <= cur_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

endmodule

### hdl/yuv444_packed_to_planar420.sv
// Top level of the packed YUV 4:4:4 to planar 4:2:0 converter.
// Depends on y2p_pkg, y2p_if, y2p_front, y2p_queue and y2p_back.
//
//   port      dir   word                          handshake
//   pix_i     in    luma_in, cb_in, cr_in         valid/ready
//   res_o     out   plane, sample, plane_index,   valid/ready
//                   last_of_item, frame_end
//   apb       in    pair_columns @0, pair_rows @4 psel/penable, pready high
//
// A pixel is taken whenever the queue is not full; the back end then gives one
// output word a cycle while the output is ready, so a left or upper-right pixel
// gives one word and a lower-right pixel three, 1.5 words a pixel over a frame
// through the single output channel. With the queue empty and the output free,
// a pixel's first word passes the queue, cur_q and res_q before it is valid.
// Reset leaves the frame at its origin; the line store needs no clearing.
// A four-word queue lets the front end run on while the output is stalled.
module yuv444_packed_to_planar420 import y2p_pkg::*; #(
  parameter int unsigned MAX_PAIR_COLUMNS = MAX_PAIR_COLUMNS_DEF,
  parameter int unsigned MAX_PAIR_ROWS    = MAX_PAIR_ROWS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  y2p_pix_if.sink            pix_i,
  y2p_res_if.source          res_o
);

  localparam int unsigned SLOT_W = (MAX_PAIR_COLUMNS > 1) ? $clog2(MAX_PAIR_COLUMNS) : 1;

  logic              push, full, pop, empty;
  item_t             push_item, head_item;
  logic [SLOT_W-1:0] push_slot, head_slot;

  y2p_front #(
    .MAX_PAIR_COLUMNS (MAX_PAIR_COLUMNS),
    .MAX_PAIR_ROWS    (MAX_PAIR_ROWS),
    .SLOT_W           (SLOT_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .pix_i       (pix_i),
    .push_o      (push),
    .push_item_o (push_item),
    .push_slot_o (push_slot),
    .full_i      (full)
  );

  y2p_queue #(
    .SLOT_W (SLOT_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .push_slot_i (push_slot),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_item_o (head_item),
    .head_slot_o (head_slot)
  );

  y2p_back #(
    .MAX_PAIR_COLUMNS (MAX_PAIR_COLUMNS),
    .SLOT_W           (SLOT_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_item_i (head_item),
    .head_slot_i (head_slot),
    .pop_o       (pop),
    .res_o       (res_o)
  );

endmodule
